// File: rtl/core/cteb_pkg.sv
package cteb_pkg;

  // default number of bytes the text store holds
  localparam int DEFAULT_CAPACITY = 1024;

  // command codes
  localparam logic [2:0] OP_LEFT      = 3'd0;
  localparam logic [2:0] OP_RIGHT     = 3'd1;
  localparam logic [2:0] OP_BACKSPACE = 3'd2;
  localparam logic [2:0] OP_INSERT    = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EDGE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // command item
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] char_in;
    logic [9:0] read_position;
  } cmd_t;

  // result item
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_char;
    logic [10:0] text_length;
    logic [10:0] cursor_position;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic rsp_valid;
  } dp_status_t;

endpackage

// File: rtl/core/cteb_controller.sv
module cteb_controller import cteb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  logic       rsp_ready,
  input  dp_status_t stat,
  output ctl_t       ctl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  // handshake and datapath commands
  assign cmd_ready   = (state == S_IDLE);
  assign ctl.capture = cmd_valid && cmd_ready;
  assign ctl.commit  = (state == S_EXEC) && (!stat.rsp_valid || rsp_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ctl.capture) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (ctl.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/cteb_datapath.sv
module cteb_datapath import cteb_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic       clk,
  input  logic       rst,
  input  ctl_t       ctl,
  output dp_status_t stat,
  input  cmd_t       cmd,
  input  logic       rsp_ready,
  output logic       rsp_valid,
  output rsp_t       rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int EW = CW + 10;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic [7:0]    text_store [CAPACITY];
  logic [CW-1:0] left_count;
  logic [CW-1:0] right_count;
  logic [CW-1:0] left_next;
  logic [CW-1:0] right_next;
  logic [CW-1:0] total;
  cmd_t          cmd_q;
  logic [7:0]    rd_data;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          we;
  logic [EW-1:0] pos_in_w;
  logic [EW-1:0] pos_q_w;
  logic [EW-1:0] left_w;
  logic [EW-1:0] total_w;
  logic [EW-1:0] gap_base_w;
  rsp_t          rsp_next;
  rsp_t          rsp_q;
  logic          rsp_valid_q;

  assign total      = left_count + right_count;
  assign pos_in_w   = EW'(cmd.read_position);
  assign pos_q_w    = EW'(cmd_q.read_position);
  assign left_w     = EW'(left_count);
  assign total_w    = EW'(total);
  assign gap_base_w = EW'(CAP - total);

  // read address, issued as the command is taken
  always_comb begin
    unique case (cmd.operation)
      OP_LEFT:  raddr = AW'(left_count - CW'(1));
      OP_RIGHT: raddr = AW'(CAP - right_count);
      OP_READ: begin
        if (pos_in_w < left_w) raddr = AW'(pos_in_w);
        else raddr = AW'(gap_base_w + pos_in_w);
      end
      default:  raddr = '0;
    endcase
  end

  // execute: write back, count update and result
  always_comb begin
    left_next          = left_count;
    right_next         = right_count;
    we                 = 1'b0;
    waddr              = AW'(left_count);
    wdata              = rd_data;
    rsp_next.status    = ST_DONE;
    rsp_next.read_char = 8'd0;
    unique case (cmd_q.operation)
      OP_LEFT: begin
        if (left_count == '0) begin
          rsp_next.status = ST_EDGE;
        end else begin
          we         = 1'b1;
          waddr      = AW'(CAP - right_count - CW'(1));
          left_next  = left_count - CW'(1);
          right_next = right_count + CW'(1);
        end
      end
      OP_RIGHT: begin
        if (right_count == '0) begin
          rsp_next.status = ST_EDGE;
        end else begin
          we         = 1'b1;
          left_next  = left_count + CW'(1);
          right_next = right_count - CW'(1);
        end
      end
      OP_BACKSPACE: begin
        if (left_count == '0) rsp_next.status = ST_EDGE;
        else left_next = left_count - CW'(1);
      end
      OP_INSERT: begin
        if (total >= CAP) begin
          rsp_next.status = ST_FULL;
        end else begin
          we        = 1'b1;
          wdata     = cmd_q.char_in;
          left_next = left_count + CW'(1);
        end
      end
      OP_READ: begin
        if (pos_q_w < total_w) rsp_next.read_char = rd_data;
        else rsp_next.status = ST_RANGE;
      end
      default: begin
      end
    endcase
    // length and cursor fields, low bits of the counts
    rsp_next.text_length     = 11'(left_next + right_next);
    rsp_next.cursor_position = 11'(left_next);
  end

  // text store, one read and one write port, read data registered
  always_ff @(posedge clk) begin
    if (ctl.capture) rd_data <= text_store[raddr];
    if (ctl.commit && we) text_store[waddr] <= wdata;
  end

  // counts and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
      rsp_valid_q <= 1'b0;
    end else if (ctl.commit) begin
      left_count  <= left_next;
      right_count <= right_next;
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (ctl.capture) cmd_q <= cmd;
    if (ctl.commit) rsp_q <= rsp_next;
  end

  assign stat.rsp_valid = rsp_valid_q;
  assign rsp_valid      = rsp_valid_q;
  assign rsp            = rsp_q;

endmodule

// File: rtl/core/cursor_text_edit_buffer.sv
// the command and its read data are registered as it is taken, the result as it completes
// a new command is taken only once the previous one completes, as the text store access needs:
//   the registered read happens as the command is taken, the write as it completes
// a result held by a stalled consumer delays the next write until it is taken
// reset: cursor and length cleared; the text store is not cleared and needs
//   no clearing pass, so commands are taken right after reset
module cursor_text_edit_buffer import cteb_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  ctl_t       ctl;
  dp_status_t stat;

  // sequencing
  cteb_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // gap buffer store, counts and result register
  cteb_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .cmd       (cmd),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

// File: rtl/core/cteb_checker.sv
module cteb_checker import cteb_pkg::*; (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // the cursor never lies beyond the end of the text
  a_cursor_in_text: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.cursor_position <= rsp.text_length)
    else $error("cursor beyond text length");

  // an out of range read returns no character
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_RANGE) |-> rsp.read_char == 8'd0)
    else $error("out of range read returned data");

  // one command at a time: no new command the cycle after one is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command taken while previous one executes");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed");

endmodule

bind cursor_text_edit_buffer cteb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// File: tb/sv/tb_cursor_text_edit_buffer.sv
`timescale 1ns / 1ps

module tb_cursor_text_edit_buffer;
  import cteb_pkg::*;

  localparam int CAP = DEFAULT_CAPACITY;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_EDITS = 150;
  localparam int NEAR_FULL_EDITS = 50;

  // command codes the block leaves without effect
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic clk;
  logic rst;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  cursor_text_edit_buffer uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  // gap buffer mirror: text left of the cursor at the bottom, right text at the top
  logic [7:0] text_mirror [0:CAP-1];
  int mirror_left = 0;
  int mirror_right = 0;

  cmd_t cmd_pending[$];
  rsp_t rsp_expected[$];
  int error_count = 0;
  int cycle_count = 0;
  logic cmd_fire = 1'b0;
  logic calm;

  // length and cursor as the command list will leave them, for shaping reads
  int gen_len = 0;
  int gen_left = 0;

  // apply one command to the mirror and return the result it should give
  function automatic rsp_t apply_edit(cmd_t c);
    rsp_t r;
    int total;
    r.status = ST_DONE;
    r.read_char = 8'h00;
    total = mirror_left + mirror_right;
    case (c.operation)
      OP_LEFT: begin
        if (mirror_left == 0) begin
          r.status = ST_EDGE;
        end else begin
          text_mirror[(CAP - mirror_right - 1) % CAP] = text_mirror[(mirror_left - 1) % CAP];
          mirror_left--;
          mirror_right++;
        end
      end
      OP_RIGHT: begin
        if (mirror_right == 0) begin
          r.status = ST_EDGE;
        end else begin
          text_mirror[mirror_left % CAP] = text_mirror[(CAP - mirror_right) % CAP];
          mirror_left++;
          mirror_right--;
        end
      end
      OP_BACKSPACE: begin
        if (mirror_left == 0) r.status = ST_EDGE;
        else mirror_left--;
      end
      OP_INSERT: begin
        if (total >= CAP) begin
          r.status = ST_FULL;
        end else begin
          text_mirror[mirror_left % CAP] = c.char_in;
          mirror_left++;
        end
      end
      OP_READ: begin
        if (int'(c.read_position) < mirror_left)
          r.read_char = text_mirror[int'(c.read_position) % CAP];
        else if (int'(c.read_position) < total)
          r.read_char = text_mirror[(CAP - total + int'(c.read_position)) % CAP];
        else
          r.status = ST_RANGE;
      end
      default: begin
      end
    endcase
    r.text_length = 11'(mirror_left + mirror_right);
    r.cursor_position = 11'(mirror_left);
    return r;
  endfunction

  // add a command to the list and track the length and cursor it leaves
  task automatic queue_cmd(logic [2:0] op, logic [7:0] ch, logic [9:0] pos);
    cmd_t c;
    c.operation = op;
    c.char_in = ch;
    c.read_position = pos;
    cmd_pending.push_back(c);
    case (op)
      OP_LEFT: if (gen_left > 0) gen_left--;
      OP_RIGHT: if (gen_left < gen_len) gen_left++;
      OP_BACKSPACE: begin
        if (gen_left > 0) begin
          gen_left--;
          gen_len--;
        end
      end
      OP_INSERT: begin
        if (gen_len < CAP) begin
          gen_left++;
          gen_len++;
        end
      end
      default: begin
      end
    endcase
  endtask

  // random command, weighted toward inserts and reads inside the text
  task automatic queue_random_edit();
    int pick;
    logic [2:0] op;
    logic [9:0] pos;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = OP_INSERT;
    else if (pick < 50) op = OP_LEFT;
    else if (pick < 65) op = OP_RIGHT;
    else if (pick < 75) op = OP_BACKSPACE;
    else if (pick < 97) op = OP_READ;
    else op = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 4) != 0)
      pos = 10'($urandom_range(0, (gen_len < CAP) ? gen_len : CAP - 1));
    else
      pos = 10'($urandom_range(0, 1023));
    queue_cmd(op, 8'($urandom_range(0, 255)), pos);
  endtask

  // compare one field of a result
  task automatic check_field(string name, logic [10:0] want, logic [10:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // a stretch of cycles in which neither side idles
  assign calm = (cycle_count >= 2000) && (cycle_count < 3000);

  // reset
  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // cycle counter
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // command driver: a new item only once the previous one is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!cmd_valid || cmd_fire) begin
        if (cmd_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 37)) begin
          cmd <= cmd_pending.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
      rsp_ready <= calm || ($urandom_range(0, 99) >= 37);
    end
  end

  // monitor: predict taken commands, check taken results
  always @(posedge clk) begin : monitor
    rsp_t want;
    if (!rst) begin
      if (cmd_valid && cmd_ready) rsp_expected.push_back(apply_edit(cmd));
      if (rsp_valid && rsp_ready) begin
        if (rsp_expected.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected, expected none, actual %p", $time, rsp);
        end else begin
          want = rsp_expected.pop_front();
          check_field("status", 11'(want.status), 11'(rsp.status));
          check_field("read_char", 11'(want.read_char), 11'(rsp.read_char));
          check_field("text_length", want.text_length, rsp.text_length);
          check_field("cursor_position", want.cursor_position, rsp.cursor_position);
        end
      end
    end
    cmd_fire <= !rst && cmd_valid && cmd_ready;
  end

  // stimulus and end of run
  initial begin
    // empty buffer: every edge case, reads out of range and spare codes
    queue_cmd(OP_LEFT, 8'h00, 10'd0);
    queue_cmd(OP_RIGHT, 8'hFF, 10'd1023);
    queue_cmd(OP_BACKSPACE, 8'h00, 10'd0);
    queue_cmd(OP_READ, 8'h00, 10'd0);
    queue_cmd(OP_READ, 8'hFF, 10'd1023);
    queue_cmd(OP_SPARE_5, 8'hFF, 10'd1023);
    queue_cmd(OP_SPARE_6, 8'h00, 10'd0);
    queue_cmd(OP_SPARE_7, 8'hA5, 10'd512);
    // short text, then reads and moves inside it
    queue_cmd(OP_INSERT, 8'h00, 10'd0);
    queue_cmd(OP_INSERT, 8'hFF, 10'd1023);
    queue_cmd(OP_INSERT, 8'h5A, 10'd0);
    queue_cmd(OP_READ, 8'h00, 10'd0);
    queue_cmd(OP_READ, 8'h00, 10'd1);
    queue_cmd(OP_READ, 8'h00, 10'd2);
    queue_cmd(OP_READ, 8'h00, 10'd3);
    queue_cmd(OP_RIGHT, 8'h00, 10'd0);
    queue_cmd(OP_LEFT, 8'h00, 10'd0);
    queue_cmd(OP_LEFT, 8'h00, 10'd0);
    queue_cmd(OP_READ, 8'h00, 10'd1);
    queue_cmd(OP_READ, 8'h00, 10'd2);
    queue_cmd(OP_INSERT, 8'hA5, 10'd0);
    queue_cmd(OP_BACKSPACE, 8'h00, 10'd0);
    queue_cmd(OP_RIGHT, 8'h00, 10'd0);
    queue_cmd(OP_READ, 8'h00, 10'd2);

    // random edits at moderate length
    repeat (RANDOM_EDITS) queue_random_edit();

    // fill to capacity, then hit the full and top-position cases
    while (gen_len < CAP)
      queue_cmd(OP_INSERT, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
    queue_cmd(OP_INSERT, 8'hFF, 10'd0);
    queue_cmd(OP_READ, 8'h00, 10'd1023);
    queue_cmd(OP_READ, 8'h00, 10'd0);
    queue_cmd(OP_LEFT, 8'h00, 10'd0);
    queue_cmd(OP_INSERT, 8'h00, 10'd0);
    queue_cmd(OP_READ, 8'h00, 10'd1023);
    repeat (NEAR_FULL_EDITS) queue_random_edit();

    // wait for every item taken and every result back
    while (cmd_pending.size() != 0 || cmd_valid || rsp_expected.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // timeout
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
